/* rtl/iu_merge_pkg.sv */
// Package for the interval union merger: store geometry, stored range format
// and sequencer states. No dependencies.
package iu_merge_pkg;

  localparam int MAX_RANGES = 64;
  localparam int IDX_W      = $clog2(MAX_RANGES);
  localparam int CNT_W      = $clog2(MAX_RANGES + 1);

  localparam logic signed [31:0] BOUND_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] BOUND_MIN = 32'sh8000_0000;

  // One closed range as held in the store; empty is lo > hi, kept at write time
  typedef struct packed {
    logic              empty;
    logic signed [31:0] lo;
    logic signed [31:0] hi;
  } span_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SORT_KEY,
    ST_SORT_KEYLD,
    ST_SORT_CMP,
    ST_SORT_PUT,
    ST_SCAN_RD0,
    ST_SCAN_FIRST,
    ST_SCAN_CMP
  } state_t;

endpackage

/* rtl/interval_union_merger.sv */
// Interval union merger top level: range store, in-place insertion sort and
// merge scan under one sequencer. Depends on iu_merge_pkg.
//
// Intervals are loaded one per input transaction and closed on
// arrival: an open left bound becomes left+1 and an open right bound becomes
// right-1, saturating at the signed 32-bit limits. Up to 64 ranges are held; a
// range arriving when the store is full is dropped, though a final_range mark on
// it still starts the merge. After the final range the block stalls its input
// while it works: unless presorted is set, a stable insertion sort by left bound
// runs in place over the store, which has one write port and one read port. The
// merge scan then reads one range per cycle, pausing when a completed range is
// due while the output register is still held by the downstream stall, and
// folds overlapping non-empty ranges together; each completed merged range is
// offered as an output transaction, run_end marking the last one. Touching
// ranges such as [a,b] and [b+1,c] stay separate, and an empty range (left
// above right) is passed on as its own result. The presorted register is
// written through the cfg channel, which is always ready; write it only while
// the block is idle.
module interval_union_merger (
  input  logic               clk,
  input  logic               rst,
  // configuration channel
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_data,
  // input channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] left_bound,
  input  logic               left_closed,
  input  logic signed [31:0] right_bound,
  input  logic               right_closed,
  input  logic               final_range,
  // output channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] merged_left,
  output logic signed [31:0] merged_right,
  output logic               run_end
);
  import iu_merge_pkg::*;

  // The last-range step shares ST_SCAN_CMP, flagged by scan_done
  localparam state_t ST_EMIT_LAST_C = ST_SCAN_CMP;

  // Registers
  state_t             state, state_next;
  logic [CNT_W-1:0]   count, count_next;   // ranges held in the store
  logic [IDX_W-1:0]   i, i_next;           // sort: position of the key
  logic [IDX_W-1:0]   j, j_next;           // sort: hole the key may drop into
  logic [IDX_W-1:0]   idx, idx_next;       // scan: entry being compared
  span_t              key, key_next;
  span_t              cur, cur_next;       // merged range being built
  logic               presorted;
  logic               scan_done, scan_done_next;
  logic               idx_done;

  // Store
  span_t              mem [MAX_RANGES];
  span_t              rdata;
  logic [IDX_W-1:0]   raddr;
  logic [IDX_W-1:0]   waddr;
  span_t              wdata;
  logic               we;

  // Misc combinational
  logic               in_fire;
  logic               out_free;
  logic               out_load;
  logic               out_last;
  logic signed [31:0] lo_c;
  logic signed [31:0] hi_c;
  span_t              in_span;
  logic [CNT_W-1:0]   n_eff;
  logic               overlap;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != ST_IDLE);
  assign in_fire   = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;

  // Close the bounds of the arriving interval
  always_comb begin
    lo_c = left_bound;
    hi_c = right_bound;
    if (!left_closed && (left_bound != BOUND_MAX)) begin
      lo_c = left_bound + 32'sd1;
    end
    if (!right_closed && (right_bound != BOUND_MIN)) begin
      hi_c = right_bound - 32'sd1;
    end
    in_span.lo    = lo_c;
    in_span.hi    = hi_c;
    in_span.empty = (lo_c > hi_c);
  end

  // Both non-empty and neither lies wholly beyond the other
  assign overlap = !cur.empty && !rdata.empty &&
                   !(rdata.hi < cur.lo) && !(cur.hi < rdata.lo);

  // Sequencer
  always_comb begin
    state_next = state;
    count_next = count;
    i_next     = i;
    j_next     = j;
    idx_next   = idx;
    key_next   = key;
    cur_next   = cur;
    raddr      = '0;
    waddr      = '0;
    wdata      = in_span;
    we         = 1'b0;
    out_load   = 1'b0;
    out_last   = 1'b0;
    n_eff      = count;

    unique case (state)
      ST_IDLE: begin
        if (in_fire) begin
          if (count < CNT_W'(MAX_RANGES)) begin
            we         = 1'b1;
            waddr      = count[IDX_W-1:0];
            wdata      = in_span;
            count_next = count + CNT_W'(1);
            n_eff      = count + CNT_W'(1);
          end
          if (final_range) begin
            if ((n_eff > CNT_W'(1)) && !presorted) begin
              i_next     = IDX_W'(1);
              state_next = ST_SORT_KEY;
            end else begin
              state_next = ST_SCAN_RD0;
            end
          end
        end
      end

      ST_SORT_KEY: begin
        raddr      = i;
        j_next     = i;
        state_next = ST_SORT_KEYLD;
      end

      ST_SORT_KEYLD: begin
        key_next   = rdata;
        raddr      = j - IDX_W'(1);
        state_next = ST_SORT_CMP;
      end

      ST_SORT_CMP: begin
        if (rdata.lo > key.lo) begin
          // shift the larger entry up one place
          we     = 1'b1;
          waddr  = j;
          wdata  = rdata;
          j_next = j - IDX_W'(1);
          if (j == IDX_W'(1)) begin
            state_next = ST_SORT_PUT;
          end else begin
            raddr = j - IDX_W'(2);
          end
        end else begin
          we    = 1'b1;
          waddr = j;
          wdata = key;
          if (({1'b0, i} + CNT_W'(1)) == count) begin
            state_next = ST_SCAN_RD0;
          end else begin
            i_next     = i + IDX_W'(1);
            j_next     = i + IDX_W'(1);
            raddr      = i + IDX_W'(1);
            state_next = ST_SORT_KEYLD;
          end
        end
      end

      ST_SORT_PUT: begin
        we    = 1'b1;
        waddr = '0;
        wdata = key;
        if (({1'b0, i} + CNT_W'(1)) == count) begin
          state_next = ST_SCAN_RD0;
        end else begin
          i_next     = i + IDX_W'(1);
          j_next     = i + IDX_W'(1);
          raddr      = i + IDX_W'(1);
          state_next = ST_SORT_KEYLD;
        end
      end

      ST_SCAN_RD0: begin
        raddr      = '0;
        state_next = ST_SCAN_FIRST;
      end

      ST_SCAN_FIRST: begin
        cur_next = rdata;
        idx_next = IDX_W'(1);
        if (count == CNT_W'(1)) begin
          state_next = ST_EMIT_LAST_C;
        end else begin
          raddr      = IDX_W'(1);
          state_next = ST_SCAN_CMP;
        end
      end

      ST_SCAN_CMP: begin
        if (idx_done) begin
          // every entry folded in: hand out the last merged range
          if (out_free) begin
            out_load   = 1'b1;
            out_last   = 1'b1;
            count_next = '0;
            state_next = ST_IDLE;
          end
        end else if (overlap || out_free) begin
          if (overlap) begin
            if (rdata.lo < cur.lo) begin
              cur_next.lo = rdata.lo;
            end
            if (rdata.hi > cur.hi) begin
              cur_next.hi = rdata.hi;
            end
          end else begin
            out_load = 1'b1;
            cur_next = rdata;
          end
          idx_next = idx + IDX_W'(1);
          raddr    = idx + IDX_W'(1);
        end else begin
          // output still held downstream: re-read the same entry
          raddr = idx;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign idx_done = scan_done;

  always_comb begin
    scan_done_next = scan_done;
    if (state == ST_IDLE) begin
      scan_done_next = 1'b0;
    end else if ((state == ST_SCAN_FIRST) && (count == CNT_W'(1))) begin
      scan_done_next = 1'b1;
    end else if ((state == ST_SCAN_CMP) && !scan_done && (overlap || out_free) &&
                 (({1'b0, idx} + CNT_W'(1)) == count)) begin
      scan_done_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      presorted <= 1'b0;
      scan_done <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      scan_done <= scan_done_next;
      if (cfg_valid && cfg_ready) begin
        presorted <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    i   <= i_next;
    j   <= j_next;
    idx <= idx_next;
    key <= key_next;
    cur <= cur_next;
  end

  // Range store, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      merged_left  <= cur.lo;
      merged_right <= cur.hi;
      run_end      <= out_last;
    end
  end

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_RANGES))
    else $error("range count above store depth");

  a_final_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && final_range |=> in_stall)
    else $error("input not stalled after final range");

  a_hole_order: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SORT_CMP) || (state == ST_SORT_KEYLD) |-> (j <= i) && (j != '0))
    else $error("sort hole outside sorted prefix");

  a_load_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ST_SCAN_CMP)
    else $error("result loaded outside merge scan");

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 100ps
// Self-checking testbench for interval_union_merger: directed and random range sets
// with random idling on both channels. Depends on iu_merge_pkg and the RTL top.
module tb_top;
  import iu_merge_pkg::*;

  localparam int RANDOM_ITEMS   = 160;
  localparam int SETTLE_CYCLES  = 16;     // extra wait; the block is idle once its last result is loaded
  localparam int TAIL_CYCLES    = 40;
  localparam int WATCHDOG_LIMIT = 20000;  // idle limit; a full sort of 64 ranges must fit under it
  localparam int MAX_REPORTS    = 10;

  // One input transaction
  typedef struct {
    logic signed [31:0] lo_bound;
    logic               lo_inc;
    logic signed [31:0] hi_bound;
    logic               hi_inc;
    logic               closes_set;
  } range_item_t;

  // A stored range, already closed on arrival
  typedef struct {
    logic signed [31:0] lo;
    logic signed [31:0] hi;
  } closed_span_t;

  // One output transaction
  typedef struct {
    logic signed [31:0] lo;
    logic signed [31:0] hi;
    logic               set_end;
  } merged_span_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic               cfg_data = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic signed [31:0] left_bound = '0;
  logic               left_closed = 1'b0;
  logic signed [31:0] right_bound = '0;
  logic               right_closed = 1'b0;
  logic               final_range = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [31:0] merged_left;
  logic signed [31:0] merged_right;
  logic               run_end;

  // Predictor state: pending ranges of the open set and the register copy
  closed_span_t span_store[MAX_RANGES];
  int           span_count  = 0;
  bit           presorted_q = 1'b0;
  merged_span_t union_q[$];   // merged ranges still owed by the block

  int fault_count = 0;
  int idle_cycles = 0;
  bit in_driving  = 1'b0;     // in_valid currently held high by us
  bit in_quiet    = 1'b0;     // sender runs back to back
  bit out_quiet   = 1'b0;     // receiver never stalls

  interval_union_merger DUT (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .left_bound  (left_bound),
    .left_closed (left_closed),
    .right_bound (right_bound),
    .right_closed(right_closed),
    .final_range (final_range),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .merged_left (merged_left),
    .merged_right(merged_right),
    .run_end     (run_end)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Union predictor: closes bounds, stores; on the set's last transaction sorts
  // stably by left bound unless presorted; folds overlapping non-empty ranges.
  // ---------------------------------------------------------------------------
  function automatic void predict_union(input range_item_t it);
    logic signed [31:0] lo;
    logic signed [31:0] hi;
    closed_span_t       work[MAX_RANGES];
    closed_span_t       cur;
    closed_span_t       key;
    closed_span_t       nx;
    merged_span_t       res;
    int                 n;
    int                 j;
    lo = it.lo_bound;
    hi = it.hi_bound;
    // open bounds step inwards, saturating at the 32-bit limits
    if (!it.lo_inc && lo != BOUND_MAX) lo = lo + 1;
    if (!it.hi_inc && hi != BOUND_MIN) hi = hi - 1;
    // a full store drops the range, but the set mark still counts
    if (span_count < MAX_RANGES) begin
      span_store[span_count] = '{lo, hi};
      span_count++;
    end
    if (!it.closes_set) return;
    n = span_count;
    for (int i = 0; i < n; i++) work[i] = span_store[i];
    // insertion sort: strict compare keeps equal left bounds in arrival order
    if (n > 1 && !presorted_q) begin
      for (int i = 1; i < n; i++) begin
        key = work[i];
        j   = i;
        while (j > 0 && work[j-1].lo > key.lo) begin
          work[j] = work[j-1];
          j--;
        end
        work[j] = key;
      end
    end
    cur = work[0];
    for (int i = 1; i < n; i++) begin
      nx = work[i];
      // empty ranges (lo > hi) never merge; touching ranges do not overlap
      if (cur.lo <= cur.hi && nx.lo <= nx.hi && nx.hi >= cur.lo && cur.hi >= nx.lo) begin
        if (nx.lo < cur.lo) cur.lo = nx.lo;
        if (nx.hi > cur.hi) cur.hi = nx.hi;
      end else begin
        res     = '{cur.lo, cur.hi, 1'b0};
        union_q = {union_q, res};
        cur = nx;
      end
    end
    res     = '{cur.lo, cur.hi, 1'b1};
    union_q = {union_q, res};
    span_count = 0;
  endfunction

  function automatic range_item_t make_range(input int lo, input bit lo_inc,
                                             input int hi, input bit hi_inc,
                                             input bit closes_set);
    range_item_t it;
    it.lo_bound   = lo;
    it.lo_inc     = lo_inc;
    it.hi_bound   = hi;
    it.hi_inc     = hi_inc;
    it.closes_set = closes_set;
    return it;
  endfunction

  task automatic log_fault(input string what);
    fault_count++;
    if (fault_count <= MAX_REPORTS) $display("%0t ns: %s", $time, what);
  endtask

  // ---------------------------------------------------------------------------
  // Input side. in_valid stays high between back-to-back transactions so that
  // it is never dropped and raised again within one time step.
  // ---------------------------------------------------------------------------
  task automatic release_input();
    if (in_driving) begin
      in_valid   <= 1'b0;
      in_driving  = 1'b0;
    end
  endtask

  task automatic send_range(input range_item_t it);
    int gap;
    gap = in_quiet ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      release_input();
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    left_bound   <= it.lo_bound;
    left_closed  <= it.lo_inc;
    right_bound  <= it.hi_bound;
    right_closed <= it.hi_inc;
    final_range  <= it.closes_set;
    in_driving    = 1'b1;
    do @(posedge clk); while (in_stall !== 1'b0);
    predict_union(it);
  endtask

  // Hold the sender until every owed merged range has been taken
  task automatic wait_drained();
    release_input();
    while (union_q.size() != 0) @(posedge clk);
  endtask

  // Register writes only with the block idle: drained, then a settle wait
  task automatic write_presorted(input bit value);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid  <= 1'b0;
    presorted_q = value;
  endtask

  // ---------------------------------------------------------------------------
  // Output side: a random stall before each transaction, then open until taken
  // ---------------------------------------------------------------------------
  initial begin
    int hold;
    @(posedge clk);
    forever begin
      hold = out_quiet ? 0 : $urandom_range(0, 14);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid === 1'b1 && out_stall === 1'b0));
    end
  end

  // Result checker: every taken transaction against the oldest owed range
  always @(posedge clk) begin
    merged_span_t want;
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (union_q.size() == 0) begin
        log_fault($sformatf("unexpected merged range [%0d,%0d] end=%0b",
                            merged_left, merged_right, run_end));
      end else begin
        want = union_q.pop_front();
        if (merged_left !== want.lo || merged_right !== want.hi || run_end !== want.set_end)
          log_fault($sformatf("merged range: expected [%0d,%0d] end=%0b, got [%0d,%0d] end=%0b",
                              want.lo, want.hi, want.set_end,
                              merged_left, merged_right, run_end));
      end
    end
  end

  // Watchdog: too long without any transaction on any channel
  always @(posedge clk) begin
    if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall) ||
        (cfg_valid && cfg_ready === 1'b1)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("[interval_union_merger] ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Single ranges, full-span bounds and saturation of open bounds at the limits
  task automatic test_extremes();
    write_presorted(1'b0);
    send_range(make_range(5, 1, 10, 1, 1));
    send_range(make_range(BOUND_MIN, 1, BOUND_MAX, 1, 1));
    // open left at the top stays at the top; open right at the bottom likewise
    send_range(make_range(BOUND_MAX, 0, BOUND_MAX, 1, 0));
    send_range(make_range(BOUND_MIN, 1, BOUND_MIN, 0, 1));
    // open bounds off the limits, bit patterns in both polarities
    send_range(make_range(32'h5555_5555, 0, 32'h5555_5560, 0, 0));
    send_range(make_range(32'hAAAA_AAAA, 0, 32'hAAAA_AAB0, 0, 1));
  endtask

  // Arrival out of order, touching vs overlapping, empty ranges, equal left bounds
  task automatic test_merge_rules();
    send_range(make_range(20, 1, 30, 1, 0));
    send_range(make_range(4, 0, 10, 1, 0));      // (4,10] closes to [5,10]
    send_range(make_range(0, 1, 4, 1, 0));       // touches [5,10], stays apart
    send_range(make_range(5, 1, 3, 1, 0));       // empty, ties with [5,10]
    send_range(make_range(25, 1, 40, 0, 0));     // overlaps [20,30]
    send_range(make_range(100, 0, 100, 0, 0));   // (100,100) is empty
    send_range(make_range(28, 1, 28, 1, 1));
    // empty range first on an equal left bound
    send_range(make_range(7, 1, 2, 1, 0));
    send_range(make_range(7, 1, 9, 1, 0));
    send_range(make_range(9, 1, 12, 1, 1));      // shares one point with [7,9]
  endtask

  // Presorted: an unordered set is scanned as it came, an ordered one merges
  task automatic test_presorted_order();
    write_presorted(1'b1);
    send_range(make_range(50, 1, 60, 1, 0));
    send_range(make_range(0, 1, 10, 1, 0));
    send_range(make_range(55, 1, 70, 1, 1));
    send_range(make_range(0, 1, 10, 1, 0));
    send_range(make_range(5, 1, 20, 1, 0));
    send_range(make_range(21, 1, 30, 1, 1));
  endtask

  // Sets longer than the store: extra ranges dropped, the set mark still acts
  task automatic test_store_overflow();
    int lo;
    write_presorted(1'b0);
    in_quiet = 1'b1;
    for (int i = 0; i <= MAX_RANGES; i++) begin
      lo = $urandom_range(0, 2000);
      send_range(make_range(lo, 1'($urandom_range(0, 1)), lo + $urandom_range(0, 40),
                            1'($urandom_range(0, 1)), i == MAX_RANGES));
    end
    write_presorted(1'b1);
    in_quiet = 1'b0;
    lo = -500;
    for (int i = 0; i <= MAX_RANGES + 1; i++) begin
      lo += $urandom_range(0, 30);
      send_range(make_range(lo, 1'($urandom_range(0, 1)), lo + $urandom_range(0, 40),
                            1'($urandom_range(0, 1)), i == MAX_RANGES + 1));
    end
  endtask

  // Random sets of mostly small size, clustered so that many ranges overlap
  task automatic test_random_sets();
    int sent;
    int set_no;
    int set_len;
    int base;
    int step;
    int lo;
    int hi;
    bit ordered;
    sent   = 0;
    set_no = 0;
    for (int phase = 0; phase < 4; phase++) begin
      write_presorted(1'(phase % 2));
      while (sent < (phase + 1) * RANDOM_ITEMS / 4) begin
        in_quiet  = ($urandom_range(0, 3) == 0);
        out_quiet = ($urandom_range(0, 3) == 0);
        set_len   = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
        // with presorted set, most sets arrive in order; the rest are broken
        ordered   = presorted_q && ($urandom_range(0, 3) != 0);
        base      = ($urandom_range(0, 4) == 0) ? $urandom() : $urandom_range(0, 400) - 200;
        step      = 0;
        for (int k = 0; k < set_len; k++) begin
          if (ordered) begin
            step += $urandom_range(0, 25);
            lo = base + step;
          end else begin
            case ($urandom_range(0, 11))
              0:       lo = $urandom();
              1:       lo = BOUND_MAX - $urandom_range(0, 2);
              2:       lo = BOUND_MIN + $urandom_range(0, 2);
              default: lo = base + $urandom_range(0, 120);
            endcase
          end
          if ($urandom_range(0, 5) == 0)
            hi = lo - $urandom_range(0, 10);    // empty or single point
          else if ($urandom_range(0, 9) == 0)
            hi = $urandom();
          else
            hi = lo + $urandom_range(0, 30);
          send_range(make_range(lo, 1'($urandom_range(0, 1)), hi, 1'($urandom_range(0, 1)),
                                k == set_len - 1));
        end
        sent += set_len;
        set_no++;
        if (set_no % 9 == 0) wait_drained();
      end
    end
    in_quiet  = 1'b0;
    out_quiet = 1'b0;
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_extremes();
    test_merge_rules();
    test_presorted_order();
    test_store_overflow();
    test_random_sets();
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fault_count == 0)
      $display("[interval_union_merger] OK");
    else
      $display("[interval_union_merger] ERROR");
    $finish;
  end

endmodule

/* files.f */
rtl/iu_merge_pkg.sv
rtl/interval_union_merger.sv
verif/tb_top.sv
